>>> rtl/yrd_pkg.sv
`timescale 1ns / 1ps

package yrd_pkg;

    // most class scores a row may carry
    localparam int MAX_CLASSES = 128;

    localparam int BOX_FIELDS = 4;
    localparam int V5_HEADER  = 5;
    localparam int FIFO_DEPTH = 4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONF_THRESH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCORE_THRESH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_X_SCALE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Y_SCALE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CLASS_COUNT = 3'd5;

    // one kept row, handed from the front end to the box arithmetic
    typedef struct packed {
        logic [6:0]         label;
        logic signed [31:0] confidence;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] w;
        logic signed [31:0] h;
    } yrd_row_t;

endpackage

>>> rtl/yrd_front.sv
`timescale 1ns / 1ps

module yrd_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] value,
    input  logic               row_end,
    input  logic               mode,
    input  logic [16:0]        confidence_threshold,
    input  logic [16:0]        score_threshold,
    input  logic [7:0]         class_count,
    input  logic               fifo_full,
    output logic               push,
    output yrd_pkg::yrd_row_t  push_row
);
    import yrd_pkg::*;

    localparam logic [8:0] MAX_CLS9 = (MAX_CLASSES > 255) ? 9'd256 : 9'(MAX_CLASSES);
    localparam logic [7:0] INDEX_MAX = 8'd255;

    logic [7:0]         idx_reg, idx_next;
    logic               seen_reg, seen_next;
    logic signed [31:0] box_reg [BOX_FIELDS];
    logic signed [31:0] obj_reg, obj_next;
    logic signed [31:0] best_reg, best_next;
    logic [6:0]         cls_reg, cls_next;

    logic               accept;
    logic [7:0]         base;
    logic [7:0]         rel;
    logic [8:0]         cnt;
    logic               is_cls;
    logic               upd;
    logic               keep;
    logic signed [31:0] thr_c;
    logic signed [31:0] thr_s;
    logic signed [31:0] box_now [BOX_FIELDS];

    assign in_ready = !fifo_full;
    assign accept   = in_valid && in_ready;

    assign base   = mode ? 8'(V5_HEADER) : 8'(BOX_FIELDS);
    assign rel    = idx_reg - base;
    assign cnt    = ({1'b0, class_count} < MAX_CLS9) ? {1'b0, class_count} : MAX_CLS9;
    assign is_cls = (idx_reg >= base) && (idx_reg != INDEX_MAX) && ({1'b0, rel} < cnt);
    // first score of a row always wins, later ones only when strictly larger
    assign upd    = is_cls && (!seen_reg || (value > best_reg));

    assign best_next = upd ? value : best_reg;
    assign cls_next  = upd ? rel[6:0] : cls_reg;
    assign seen_next = seen_reg || is_cls;
    assign obj_next  = (idx_reg == 8'(BOX_FIELDS)) ? value : obj_reg;

    always_comb
    begin
        for (int i = 0; i < BOX_FIELDS; i++)
        begin
            box_now[i] = (idx_reg == 8'(i)) ? value : box_reg[i];
        end
    end

    assign thr_c = $signed({15'd0, confidence_threshold});
    assign thr_s = $signed({15'd0, score_threshold});

    always_comb
    begin
        if (!seen_next)
        begin
            keep = 1'b0;
        end
        else if (mode)
        begin
            keep = (obj_next >= thr_c) && (best_next > thr_s);
        end
        else
        begin
            keep = best_next > thr_c;
        end
    end

    assign push                = accept && row_end && keep;
    assign push_row.label      = cls_next;
    assign push_row.confidence = mode ? obj_next : best_next;
    assign push_row.x          = box_now[0];
    assign push_row.y          = box_now[1];
    assign push_row.w          = box_now[2];
    assign push_row.h          = box_now[3];

    always_comb
    begin
        if (row_end)
        begin
            idx_next = 8'd0;
        end
        else if (idx_reg != INDEX_MAX)
        begin
            idx_next = idx_reg + 8'd1;
        end
        else
        begin
            idx_next = idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= 8'd0;
            seen_reg <= 1'b0;
        end
        else if (accept)
        begin
            idx_reg  <= idx_next;
            seen_reg <= row_end ? 1'b0 : seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (idx_reg < 8'(BOX_FIELDS))
            begin
                box_reg[idx_reg[1:0]] <= value;
            end
            obj_reg  <= obj_next;
            best_reg <= best_next;
            cls_reg  <= cls_next;
        end
    end

endmodule

>>> rtl/yrd_fifo.sv
`timescale 1ns / 1ps

module yrd_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  yrd_pkg::yrd_row_t push_row,
    input  logic              pop,
    output yrd_pkg::yrd_row_t pop_row,
    output logic              full,
    output logic              empty
);
    import yrd_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    yrd_row_t           mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full    = count_reg == CNT_W'(FIFO_DEPTH);
    assign empty   = count_reg == '0;
    assign pop_row = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_row;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("fifo count beyond depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full fifo");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("pop from empty fifo");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("fifo count did not track push");
`endif

endmodule

>>> rtl/yrd_back.sv
`timescale 1ns / 1ps

module yrd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fifo_empty,
    input  yrd_pkg::yrd_row_t  pop_row,
    output logic               pop,
    input  logic [15:0]        x_scale,
    input  logic [15:0]        y_scale,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [6:0]         label,
    output logic signed [31:0] confidence,
    output logic signed [15:0] left,
    output logic signed [15:0] top,
    output logic signed [15:0] box_width,
    output logic signed [15:0] box_height
);
    import yrd_pkg::*;

    // divide by 2^sh rounding toward zero, then clamp to 16 bits
    function automatic logic signed [15:0] trunc_sat(input logic signed [50:0] p,
                                                     input logic [4:0] sh);
        logic signed [50:0] bias;
        logic signed [50:0] q;
        bias = p[50] ? $signed((51'd1 << sh) - 51'd1) : 51'sd0;
        q    = (p + bias) >>> sh;
        if (q > 51'sd32767)
        begin
            trunc_sat = 16'sh7fff;
        end
        else if (q < -51'sd32768)
        begin
            trunc_sat = 16'sh8000;
        end
        else
        begin
            trunc_sat = q[15:0];
        end
    endfunction

    logic               adv;

    // stage 1: corner offsets, 2x - w carries one extra fraction bit
    logic               v1_reg;
    logic signed [33:0] lxd_reg;
    logic signed [33:0] tyd_reg;
    logic signed [31:0] w1_reg;
    logic signed [31:0] h1_reg;
    logic [6:0]         cls1_reg;
    logic signed [31:0] conf1_reg;

    // stage 2: products
    logic               v2_reg;
    logic signed [50:0] lxp_reg, lxp_next;
    logic signed [50:0] typ_reg, typ_next;
    logic signed [50:0] wp_reg, wp_next;
    logic signed [50:0] hp_reg, hp_next;
    logic [6:0]         cls2_reg;
    logic signed [31:0] conf2_reg;

    // stage 3: output word
    logic               out_valid_reg;
    logic [6:0]         cls_o_reg;
    logic signed [31:0] conf_o_reg;
    logic signed [15:0] left_reg;
    logic signed [15:0] top_reg;
    logic signed [15:0] bw_reg;
    logic signed [15:0] bh_reg;

    logic signed [16:0] xs;
    logic signed [16:0] ys;

    assign adv = !out_valid_reg || out_ready;
    assign pop = adv && !fifo_empty;

    assign xs = $signed({1'b0, x_scale});
    assign ys = $signed({1'b0, y_scale});

    assign lxp_next = lxd_reg * xs;
    assign typ_next = tyd_reg * ys;
    assign wp_next  = w1_reg * xs;
    assign hp_next  = h1_reg * ys;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= !fifo_empty;
            v2_reg        <= v1_reg;
            out_valid_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lxd_reg   <= ($signed({pop_row.x[31], pop_row.x, 1'b0}) -
                          $signed({{2{pop_row.w[31]}}, pop_row.w}));
            tyd_reg   <= ($signed({pop_row.y[31], pop_row.y, 1'b0}) -
                          $signed({{2{pop_row.h[31]}}, pop_row.h}));
            w1_reg    <= pop_row.w;
            h1_reg    <= pop_row.h;
            cls1_reg  <= pop_row.label;
            conf1_reg <= pop_row.confidence;

            lxp_reg   <= lxp_next;
            typ_reg   <= typ_next;
            wp_reg    <= wp_next;
            hp_reg    <= hp_next;
            cls2_reg  <= cls1_reg;
            conf2_reg <= conf1_reg;

            cls_o_reg  <= cls2_reg;
            conf_o_reg <= conf2_reg;
            left_reg   <= trunc_sat(lxp_reg, 5'd25);
            top_reg    <= trunc_sat(typ_reg, 5'd25);
            bw_reg     <= trunc_sat(wp_reg, 5'd24);
            bh_reg     <= trunc_sat(hp_reg, 5'd24);
        end
    end

    assign out_valid  = out_valid_reg;
    assign label      = cls_o_reg;
    assign confidence = conf_o_reg;
    assign left       = left_reg;
    assign top        = top_reg;
    assign box_width  = bw_reg;
    assign box_height = bh_reg;

endmodule

>>> rtl/yolo_row_decode.sv
// A kept row is queued when its row_end word is taken, then passes box stages 1, 2 and 3 in order.
// Throughput: one input word per cycle; at most one result per row, one per cycle.
// The front end stalls only when its 4-entry row queue is full; the box multipliers
// run as a 3-stage pipeline that holds as a whole while the output word waits.
// Reset (rst_n, async, active low) restores register defaults and empties all stages.
`timescale 1ns / 1ps

module yolo_row_decode (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [yrd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [yrd_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [31:0]                  value,
    input  logic                                row_end,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [6:0]                          label,
    output logic signed [31:0]                  confidence,
    output logic signed [15:0]                  left,
    output logic signed [15:0]                  top,
    output logic signed [15:0]                  box_width,
    output logic signed [15:0]                  box_height
);
    import yrd_pkg::*;

    logic        mode_reg;
    logic [16:0] conf_thr_reg;
    logic [16:0] score_thr_reg;
    logic [15:0] x_scale_reg;
    logic [15:0] y_scale_reg;
    logic [7:0]  class_count_reg;

    logic        push;
    logic        pop;
    logic        fifo_full;
    logic        fifo_empty;
    yrd_row_t    push_row;
    yrd_row_t    pop_row;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= 1'b0;
            conf_thr_reg    <= 17'd16384;
            score_thr_reg   <= 17'd16384;
            x_scale_reg     <= 16'd256;
            y_scale_reg     <= 16'd256;
            class_count_reg <= 8'd80;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MODE:         mode_reg        <= cfg_data[0];
                REG_CONF_THRESH:  conf_thr_reg    <= cfg_data;
                REG_SCORE_THRESH: score_thr_reg   <= cfg_data;
                REG_X_SCALE:      x_scale_reg     <= cfg_data[15:0];
                REG_Y_SCALE:      y_scale_reg     <= cfg_data[15:0];
                REG_CLASS_COUNT:  class_count_reg <= cfg_data[7:0];
                default:          ;
            endcase
        end
    end

    yrd_front u_front (
        .clk                  (clk),
        .rst_n                (rst_n),
        .in_valid             (in_valid),
        .in_ready             (in_ready),
        .value                (value),
        .row_end              (row_end),
        .mode                 (mode_reg),
        .confidence_threshold (conf_thr_reg),
        .score_threshold      (score_thr_reg),
        .class_count          (class_count_reg),
        .fifo_full            (fifo_full),
        .push                 (push),
        .push_row             (push_row)
    );

    yrd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_row (push_row),
        .pop      (pop),
        .pop_row  (pop_row),
        .full     (fifo_full),
        .empty    (fifo_empty)
    );

    yrd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_empty (fifo_empty),
        .pop_row    (pop_row),
        .pop        (pop),
        .x_scale    (x_scale_reg),
        .y_scale    (y_scale_reg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .label      (label),
        .confidence (confidence),
        .left       (left),
        .top        (top),
        .box_width  (box_width),
        .box_height (box_height)
    );

endmodule

>>> test/tb_yolo_row_decode.sv
`timescale 1ns / 1ps

module tb_yolo_row_decode;
    import yrd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    localparam int ROW_POS_MAX  = 255;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_WORDS  = 140;
    localparam int TOTAL_WORDS  = 1150;
    localparam int CYCLE_LIMIT  = 150000;

    typedef struct packed {
        logic signed [31:0] v;
        logic               last;
    } row_word_t;

    typedef struct packed {
        logic [6:0]         cls;
        logic signed [31:0] conf;
        logic signed [15:0] l;
        logic signed [15:0] t;
        logic signed [15:0] w;
        logic signed [15:0] h;
    } det_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic signed [31:0]    value = '0;
    logic                  row_end = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [6:0]            label;
    logic signed [31:0]    confidence;
    logic signed [15:0]    left;
    logic signed [15:0]    top;
    logic signed [15:0]    box_width;
    logic signed [15:0]    box_height;

    yolo_row_decode u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .value      (value),
        .row_end    (row_end),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .label      (label),
        .confidence (confidence),
        .left       (left),
        .top        (top),
        .box_width  (box_width),
        .box_height (box_height)
    );

    always #6 clk = ~clk;

    // register copy
    int     cfg_mode    = 0;
    longint cfg_conf    = 16384;
    longint cfg_score   = 16384;
    longint cfg_xs      = 256;
    longint cfg_ys      = 256;
    int     cfg_classes = 80;

    // decoder state copy
    int     row_pos = 0;
    longint box_q[BOX_FIELDS];
    longint obj_q;
    longint best_q;
    int     best_cls;
    bit     any_class = 1'b0;

    row_word_t row_words[$];
    det_t      want_dets[$];
    row_word_t drv_word;
    det_t      got_det;
    det_t      want_det;

    bit  in_took = 1'b0;
    bit  out_took = 1'b0;
    bit  in_fast = 1'b0;
    bit  out_fast = 1'b0;
    bit  hold_arm = 1'b0;
    bit  hold_done = 1'b0;
    int  in_gap = 0;
    int  out_wait = 0;
    int  hold_left = 0;
    int  mismatches = 0;
    int  cycles = 0;

    // divide by 2^sh toward zero, clamp to int16
    function automatic logic signed [15:0] px_sat(input longint p, input int sh);
        longint q;
        q = p / (longint'(1) << sh);
        if (q > 32767)
            q = 32767;
        else if (q < -32768)
            q = -32768;
        return q[15:0];
    endfunction

    function automatic void decode_word(input logic signed [31:0] v, input logic last);
        longint sv;
        longint conf;
        int     base;
        int     eff;
        bit     keep;
        det_t   d;
        sv   = longint'(v);
        base = cfg_mode ? V5_HEADER : BOX_FIELDS;
        eff  = cfg_classes < MAX_CLASSES ? cfg_classes : MAX_CLASSES;
        if (row_pos < BOX_FIELDS)
            box_q[row_pos] = sv;
        // element four is always objectness, and class 0 as well in v8 layout
        if (row_pos == BOX_FIELDS)
            obj_q = sv;
        if (row_pos >= base && row_pos < ROW_POS_MAX && row_pos - base < eff)
        begin
            if (!any_class || sv > best_q)
            begin
                best_q   = sv;
                best_cls = row_pos - base;
            end
            any_class = 1'b1;
        end
        if (last)
        begin
            keep = 1'b0;
            conf = 0;
            if (any_class)
            begin
                if (cfg_mode != 0)
                begin
                    keep = obj_q >= cfg_conf && best_q > cfg_score;
                    conf = obj_q;
                end
                else
                begin
                    keep = best_q > cfg_conf;
                    conf = best_q;
                end
            end
            if (keep)
            begin
                d.cls  = best_cls[6:0];
                d.conf = conf[31:0];
                // 2x - w carries one more fraction bit, hence the shift of 25
                d.l    = px_sat((2 * box_q[0] - box_q[2]) * cfg_xs, 25);
                d.t    = px_sat((2 * box_q[1] - box_q[3]) * cfg_ys, 25);
                d.w    = px_sat(box_q[2] * cfg_xs, 24);
                d.h    = px_sat(box_q[3] * cfg_ys, 24);
                want_dets.insert(want_dets.size(), d);
            end
            row_pos   = 0;
            any_class = 1'b0;
        end
        else if (row_pos < ROW_POS_MAX)
            row_pos = row_pos + 1;
    endfunction

    function automatic void put_word(input logic [31:0] v, input logic last);
        row_word_t w;
        w.v    = v;
        w.last = last;
        row_words.insert(row_words.size(), w);
    endfunction

    // mostly close to a threshold so both outcomes turn up
    function automatic logic [31:0] near(input longint centre);
        longint r;
        case ($urandom_range(0, 7))
            0: r = centre;
            1: r = centre + 1;
            2: r = centre - 1;
            3: r = longint'($urandom);
            default: r = centre + longint'($urandom_range(0, 131072)) - 65536;
        endcase
        return r[31:0];
    endfunction

    // len of 0 picks a shape: mostly whole rows, some short or ragged ones
    function automatic int queue_row(input int len);
        int          base;
        int          eff;
        int          k;
        int          i;
        logic [31:0] v;
        base = cfg_mode ? V5_HEADER : BOX_FIELDS;
        eff  = cfg_classes < MAX_CLASSES ? cfg_classes : MAX_CLASSES;
        if (len == 0)
        begin
            k = $urandom_range(0, 9);
            if (k < 7)
                len = base + eff + (k == 0 ? $urandom_range(1, 3) : 0);
            else if (k < 9)
                len = $urandom_range(1, base);
            else
                len = $urandom_range(1, base + eff + 4);
        end
        for (i = 0; i < len; i++)
        begin
            if (i < BOX_FIELDS)
                v = ($urandom_range(0, 3) == 0) ? $urandom
                                                : $urandom_range(0, 1 << 23) - (1 << 22);
            else if (i == BOX_FIELDS && cfg_mode != 0)
                v = near(cfg_conf);
            else
                v = near(cfg_mode != 0 ? cfg_score : cfg_conf);
            put_word(v, i == len - 1);
        end
        return len;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_thresh();
        case ($urandom_range(0, 7))
            0: return 17'd0;
            1: return 17'd65536;
            2: return 17'($urandom_range(65537, 131071));
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_scale();
        logic [15:0] s;
        case ($urandom_range(0, 5))
            0: s = 16'd0;
            1: s = 16'hFFFF;
            2: s = 16'd256;
            default: s = 16'($urandom);
        endcase
        return {1'($urandom_range(0, 1)), s};
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_MODE:         cfg_mode    = data[0];
            REG_CONF_THRESH:  cfg_conf    = data[16:0];
            REG_SCORE_THRESH: cfg_score   = data[16:0];
            REG_X_SCALE:      cfg_xs      = data[15:0];
            REG_Y_SCALE:      cfg_ys      = data[15:0];
            REG_CLASS_COUNT:  cfg_classes = data[7:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        @(posedge clk);
        while (row_words.size() != 0 || in_valid || want_dets.size() != 0)
            @(posedge clk);
        // rows that give nothing may still be in flight
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic random_setup(input int ph);
        logic [CFG_DATA_W-1:0] d;
        int                    cnt;
        d = 17'($urandom);
        if (ph == 0)
            d[0] = 1'b0;
        else if (ph == 1)
            d[0] = 1'b1;
        cfg_write(REG_MODE, d);
        cfg_write(REG_CONF_THRESH, ph == 0 ? 17'd0 : pick_thresh());
        cfg_write(REG_SCORE_THRESH, pick_thresh());
        cfg_write(REG_X_SCALE, pick_scale());
        cfg_write(REG_Y_SCALE, pick_scale());
        case ($urandom_range(0, 19))
            0: cnt = 0;
            1: cnt = 128;
            2: cnt = $urandom_range(129, 255);
            3, 4, 5: cnt = $urandom_range(7, 24);
            default: cnt = $urandom_range(1, 6);
        endcase
        if (ph == 0)
            cnt = $urandom_range(1, 4);
        else if (ph == 1)
            cnt = 255;
        d        = 17'($urandom);
        d[7:0]   = cnt[7:0];
        cfg_write(REG_CLASS_COUNT, d);
    endtask

    // sample handshakes, predict on every accepted word, check every result
    always @(posedge clk)
    begin
        in_took  = rst_n && in_valid && in_ready;
        out_took = rst_n && out_valid && out_ready;
        if (in_took)
            decode_word(value, row_end);
        if (out_took)
        begin
            got_det = {label, confidence, left, top, box_width, box_height};
            if (want_dets.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: cls=%0d conf=%0d box=%0d,%0d,%0d,%0d",
                             got_det.cls, got_det.conf, got_det.l, got_det.t,
                             got_det.w, got_det.h);
            end
            else
            begin
                want_det = want_dets.pop_front();
                if (got_det.cls !== want_det.cls || got_det.conf !== want_det.conf ||
                    got_det.l !== want_det.l || got_det.t !== want_det.t ||
                    got_det.w !== want_det.w || got_det.h !== want_det.h)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: want cls=%0d conf=%0d box=%0d,%0d,%0d,%0d",
                                  " got cls=%0d conf=%0d box=%0d,%0d,%0d,%0d"},
                                 want_det.cls, want_det.conf, want_det.l, want_det.t,
                                 want_det.w, want_det.h, got_det.cls, got_det.conf,
                                 got_det.l, got_det.t, got_det.w, got_det.h);
                end
            end
        end
    end

    // word driver: random gap before each word, valid held until taken
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_took))
        begin
            if (in_gap > 0)
            begin
                in_gap = in_gap - 1;
                in_valid <= 1'b0;
            end
            else if (row_words.size() != 0)
            begin
                drv_word = row_words.pop_front();
                value    <= drv_word.v;
                row_end  <= drv_word.last;
                in_valid <= 1'b1;
                in_gap   = in_fast ? 0 : $urandom_range(0, 6);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result sink: random stall per result, one long hold-off when armed
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_took)
                out_wait = out_fast ? 0 : $urandom_range(0, 6);
            if (hold_arm && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (out_wait > 0)
            begin
                out_wait = out_wait - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        int sent;
        int ph;
        int phase_words;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // v8 layout, saturating box, extra score ignored, then a short row
        cfg_write(REG_MODE, 17'd0);
        cfg_write(REG_CONF_THRESH, 17'd0);
        cfg_write(REG_SCORE_THRESH, 17'h1FFFF);
        cfg_write(REG_X_SCALE, 17'h0FFFF);
        cfg_write(REG_Y_SCALE, 17'h0FFFF);
        cfg_write(REG_CLASS_COUNT, 17'd1);
        cfg_write(REG_SPARE_6, 17'($urandom));
        cfg_write(REG_SPARE_7, 17'($urandom));
        @(posedge clk);
        put_word(32'h7FFFFFFF, 1'b0);
        put_word(32'h80000000, 1'b0);
        put_word(32'h80000000, 1'b0);
        put_word(32'h7FFFFFFF, 1'b0);
        put_word(32'd5, 1'b0);
        put_word(32'd6, 1'b1);
        put_word(32'd1, 1'b0);
        put_word(32'd2, 1'b0);
        put_word(32'd3, 1'b1);
        wait_idle();

        // v5 layout: objectness on its threshold, score on its threshold
        cfg_write(REG_MODE, 17'd1);
        cfg_write(REG_CONF_THRESH, 17'd65536);
        cfg_write(REG_SCORE_THRESH, 17'd0);
        cfg_write(REG_X_SCALE, 17'd0);
        cfg_write(REG_Y_SCALE, 17'd256);
        @(posedge clk);
        put_word(32'h00010000, 1'b0);
        put_word(32'hFFFE0000, 1'b0);
        put_word(32'h00008000, 1'b0);
        put_word(32'hFFFF8000, 1'b0);
        put_word(32'd65536, 1'b0);
        put_word(32'd1, 1'b1);
        put_word(32'h00030000, 1'b0);
        put_word(32'h00040000, 1'b0);
        put_word(32'h00050000, 1'b0);
        put_word(32'h00060000, 1'b0);
        put_word(32'h7FFFFFFF, 1'b0);
        put_word(32'd0, 1'b1);
        // row left open across a mode change
        put_word(32'h00100000, 1'b0);
        put_word(32'h00200000, 1'b0);
        put_word(32'h00080000, 1'b0);
        put_word(32'h00040000, 1'b0);
        wait_idle();
        cfg_write(REG_MODE, 17'd0);
        @(posedge clk);
        put_word(32'h7FFFFFFF, 1'b1);
        wait_idle();

        // no classes: nothing is ever kept
        cfg_write(REG_CLASS_COUNT, 17'd0);
        @(posedge clk);
        put_word(32'd7, 1'b0);
        put_word(32'd7, 1'b0);
        put_word(32'd7, 1'b0);
        put_word(32'd7, 1'b0);
        put_word(32'h7FFFFFFF, 1'b1);

        sent = 0;
        ph   = 0;
        while (sent < TOTAL_WORDS)
        begin
            wait_idle();
            random_setup(ph);
            @(posedge clk);
            in_fast  = (ph % 4 == 3) || ($urandom_range(0, 3) == 0);
            out_fast = (ph % 4 == 3) || ($urandom_range(0, 3) == 0);
            if (ph == 0)
            begin
                out_fast = 1'b0;
                hold_arm = 1'b1;
            end
            phase_words = 0;
            // one overlong row to run the element index into its stop
            if (ph == 2)
                phase_words += queue_row(256 + $urandom_range(0, 40));
            while (phase_words < PHASE_WORDS && sent + phase_words < TOTAL_WORDS)
                phase_words += queue_row(0);
            sent += phase_words;
            ph++;
        end
        wait_idle();

        if (mismatches == 0 && want_dets.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> files.f
rtl/yrd_pkg.sv
rtl/yrd_front.sv
rtl/yrd_fifo.sv
rtl/yrd_back.sv
rtl/yolo_row_decode.sv
test/tb_yolo_row_decode.sv
